// ----- rtl/pfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pfd_pkg
// Types, constants and codes shared by the per-source flood detector.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

  localparam int PROTO_W  = 8;
  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 16;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 10;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int REC_W    = CNT_W + TIME_W;

  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd50;
  localparam logic [CFG_W-1:0] WINDOW_RESET    = 16'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS  = 1'd1;

  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COUNTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALERT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_FETCH,
    S_UPDATE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic scan;
    logic take_hit;
    logic append;
    logic update;
    logic res_ignored;
    logic res_full;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic is_udp;
    logic hit;
    logic miss_done;
    logic full;
  } stat_t;

endpackage

// ----- rtl/pfd_ram.sv -----
// ----------------------------------------------------------------------------
// pfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/pfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfd_ctrl
// Sequencer: search, fetch, update and hand-off of one packet transaction.
// ----------------------------------------------------------------------------
module pfd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  pfd_pkg::stat_t stat,
  output pfd_pkg::cmd_t  cmd
);
  import pfd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        priority if (!stat.is_udp) state_nxt = S_FINISH;
        else if (stat.hit) state_nxt = S_FETCH;
        else if (stat.miss_done && stat.full) state_nxt = S_FINISH;
        else if (stat.miss_done) state_nxt = S_UPDATE;
        else state_nxt = S_SEARCH;
      end
      S_FETCH:  state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_in = in_valid;
      end
      S_SEARCH: begin
        priority if (!stat.is_udp) cmd.res_ignored = 1'b1;
        else if (stat.hit) cmd.take_hit = 1'b1;
        else if (stat.miss_done && stat.full) cmd.res_full = 1'b1;
        else if (stat.miss_done) cmd.append = 1'b1;
        else cmd.scan = 1'b1;
      end
      S_FETCH:  ;
      S_UPDATE: cmd.update = 1'b1;
      S_FINISH: cmd.out_ld = out_free;
      default:  ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_ld) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/pfd_datapath.sv -----
// ----------------------------------------------------------------------------
// pfd_datapath
// Source table, window records, config registers and result registers.
// ----------------------------------------------------------------------------
module pfd_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfd_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [pfd_pkg::PROTO_W-1:0]      in_ip_protocol,
  input  logic [pfd_pkg::ADDR_W-1:0]       in_src_addr,
  input  logic [pfd_pkg::TIME_W-1:0]       in_now_seconds,
  output logic [pfd_pkg::STATUS_W-1:0]     out_status,
  output logic [pfd_pkg::ENTRY_W-1:0]      out_entry_index,
  output logic [pfd_pkg::CNT_W-1:0]        out_packet_count,
  input  pfd_pkg::cmd_t                    cmd,
  output pfd_pkg::stat_t                   stat
);
  import pfd_pkg::*;

  logic [CFG_W-1:0]   threshold_r, window_r;
  logic [PROTO_W-1:0] proto_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [TIME_W-1:0]  now_r;
  logic [USED_W-1:0]  used_r;
  logic [USED_W-1:0]  scan_idx_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   slot_r;
  logic               new_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [ENTRY_W-1:0]  res_index_r;
  logic [CNT_W-1:0]    res_count_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ENTRY_W-1:0]  out_index_r;
  logic [CNT_W-1:0]    out_count_r;

  logic [ADDR_W-1:0] tab_rdata;
  logic [REC_W-1:0]  rec_rdata;
  logic [REC_W-1:0]  rec_wdata;
  logic              issue;

  logic [CNT_W-1:0]  base_cnt, cnt_inc;
  logic [TIME_W-1:0] base_start, start_new, elapsed;
  logic              restart, alert;

  assign issue = cmd.scan && (scan_idx_r < used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      window_r    <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOOD_THRESHOLD: threshold_r <= cfg_wdata;
        CFG_WINDOW_SECONDS:  window_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cmd.append) used_r <= used_r + USED_W'(1);
      if (cmd.load_in) cmp_vld_r <= 1'b0;
      else             cmp_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      proto_r    <= in_ip_protocol;
      addr_r     <= in_src_addr;
      now_r      <= in_now_seconds;
      scan_idx_r <= '0;
    end else if (issue) begin
      scan_idx_r <= scan_idx_r + USED_W'(1);
    end
    cmp_idx_r <= scan_idx_r[IDX_W-1:0];
    if (cmd.take_hit) begin
      slot_r <= cmp_idx_r;
      new_r  <= 1'b0;
    end else if (cmd.append) begin
      slot_r <= used_r[IDX_W-1:0];
      new_r  <= 1'b1;
    end
  end

  assign stat.is_udp    = (proto_r == PROTO_UDP);
  assign stat.hit       = cmp_vld_r && (tab_rdata == addr_r);
  assign stat.miss_done = !cmp_vld_r && (scan_idx_r >= used_r);
  assign stat.full      = (used_r == USED_W'(TABLE_DEPTH));

  pfd_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_src_tab (
    .clk     (clk),
    .wr_en   (cmd.append),
    .wr_addr (used_r[IDX_W-1:0]),
    .wr_data (addr_r),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (tab_rdata)
  );

  // record = {count, window start}
  always_comb begin
    base_cnt   = new_r ? '0    : rec_rdata[REC_W-1 -: CNT_W];
    base_start = new_r ? now_r : rec_rdata[TIME_W-1:0];
    elapsed    = now_r - base_start;
    restart    = elapsed > TIME_W'(window_r);
    start_new  = restart ? now_r : base_start;
    cnt_inc    = restart ? CNT_W'(1)
               : ((base_cnt == '1) ? base_cnt : base_cnt + CNT_W'(1));
    alert      = cnt_inc > threshold_r;
    rec_wdata  = {(alert ? CNT_W'(0) : cnt_inc), start_new};
  end

  pfd_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_rec_tab (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (slot_r),
    .wr_data (rec_wdata),
    .rd_addr (slot_r),
    .rd_data (rec_rdata)
  );

  always_ff @(posedge clk) begin
    priority if (cmd.res_ignored) begin
      res_status_r <= ST_IGNORED;
      res_index_r  <= '0;
      res_count_r  <= '0;
    end else if (cmd.res_full) begin
      res_status_r <= ST_FULL;
      res_index_r  <= '0;
      res_count_r  <= '0;
    end else if (cmd.update) begin
      res_status_r <= alert ? ST_ALERT : ST_COUNTED;
      res_index_r  <= ENTRY_W'(slot_r);
      res_count_r  <= cnt_inc;
    end else begin
      res_status_r <= res_status_r;
      res_index_r  <= res_index_r;
      res_count_r  <= res_count_r;
    end
    if (cmd.out_ld) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_count_r  <= res_count_r;
    end
  end

  assign out_status       = out_status_r;
  assign out_entry_index  = out_index_r;
  assign out_packet_count = out_count_r;

endmodule

// ----- rtl/per_source_flood_detector.sv -----
// Path to result valid: a non-UDP packet goes from search to finish; a hit scans
//   to its slot, fetches, updates; a new source scans all entries, appends, updates;
//   a full table drops the packet after the scan. One transaction at a time; the next
//   is taken the cycle after the result loads. The linear scan reads one entry per cycle.
// Reset (rst_n, synchronous, active low) empties the table and loads the threshold
//   to 50 and the window to 1 second; table contents are not cleared.
// ----------------------------------------------------------------------------
// per_source_flood_detector
// Per-source UDP packet rate detector with fixed windows and flood alerts.
// ----------------------------------------------------------------------------
module per_source_flood_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfd_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfd_pkg::PROTO_W-1:0]   in_ip_protocol,
  input  logic [pfd_pkg::ADDR_W-1:0]    in_src_addr,
  input  logic [pfd_pkg::TIME_W-1:0]    in_now_seconds,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfd_pkg::STATUS_W-1:0]  out_status,
  output logic [pfd_pkg::ENTRY_W-1:0]   out_entry_index,
  output logic [pfd_pkg::CNT_W-1:0]     out_packet_count
);
  import pfd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_ip_protocol   (in_ip_protocol),
    .in_src_addr      (in_src_addr),
    .in_now_seconds   (in_now_seconds),
    .out_status       (out_status),
    .out_entry_index  (out_entry_index),
    .out_packet_count (out_packet_count),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

// ----- rtl/pfd_checker.sv -----
// ----------------------------------------------------------------------------
// pfd_checker
// Port-level checks on the flood detector, bound to the top level.
// ----------------------------------------------------------------------------
module pfd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pfd_pkg::STATUS_W-1:0]  out_status,
  input  logic [pfd_pkg::ENTRY_W-1:0]   out_entry_index,
  input  logic [pfd_pkg::CNT_W-1:0]     out_packet_count
);
  import pfd_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_entry_index) && $stable(out_packet_count))
    else $error("stalled result transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous transaction in flight");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IGNORED || out_status == ST_FULL)
      |-> out_entry_index == '0 && out_packet_count == '0)
    else $error("ignored or dropped result carries nonzero fields");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_COUNTED || out_status == ST_ALERT)
      |-> out_packet_count != '0)
    else $error("counted result with zero count");

endmodule

bind per_source_flood_detector pfd_checker u_pfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_entry_index  (out_entry_index),
  .out_packet_count (out_packet_count)
);
